// ----- src/mst_pkg.sv -----
// mst_pkg: shared types and constants for the multi-slot software timer
// holds opcode and result kind codes, beat structs and controller status
// no dependencies
package mst_pkg;

  // default number of timer slots
  localparam int SLOTS_DEF = 16;

  // timer count and per-slot word widths
  localparam int TW = 32;

  // opcodes of an input beat
  typedef enum logic [2:0] {
    OP_TICK    = 3'd0,
    OP_LOAD    = 3'd1,
    OP_START   = 3'd2,
    OP_STOP    = 3'd3,
    OP_SERVICE = 3'd4
  } opcode_t;

  // result kinds
  typedef enum logic [1:0] {
    KIND_ACK   = 2'd0,
    KIND_BUSY  = 2'd1,
    KIND_FIRED = 2'd2,
    KIND_NONE  = 2'd3
  } kind_t;

  // input beat
  typedef struct packed {
    logic [2:0]    opcode;
    logic [3:0]    slot;
    logic [TW-1:0] delay;
    logic [TW-1:0] period;
  } in_t;

  // result beat
  typedef struct packed {
    logic [1:0] kind;
    logic [3:0] fired_slot;
    logic       last;
  } out_t;

  // scan controller states
  typedef enum logic [1:0] {
    ST_IDLE  = 2'd0,
    ST_SCAN  = 2'd1,
    ST_FLUSH = 2'd2
  } state_t;

  // controller status toward the datapath
  typedef struct packed {
    logic busy;
    logic rd_en;
    logic proc_valid;
    logic flush;
  } ctrl_t;

endpackage

// ----- src/multi_slot_software_timer.sv -----
// multi_slot_software_timer: bank of timer slots sharing one tick counter
// depends on mst_pkg, mst_ram, mst_ctrl
//
// Usage: drive in_data and raise start; the beat is taken at a clock edge
// where start is high and busy is low. Results appear on out_data for one
// cycle each, marked by out_valid; the receiver must take them as they come
// and cannot stall the block.
// Timing and throughput: tick, load, start, stop and unknown opcodes
// answer with one beat in the next cycle; busy stays low, so such beats
// may be given every cycle. service scans the slot memory one entry per
// cycle through its single read port, pipelined against the write-back
// of the previous entry, and holds busy while it runs.
// Fired beats leave during the scan, one behind the slot that found the
// next hit; the final beat (last set) is on the ports in the same cycle
// as busy falls.
// Reset clears the tick count, the active bits and the per-slot loaded
// bits; an entry never loaded reads as zero deadline and zero interval, so
// no clearing pass is needed and the block takes a beat right after reset.
module multi_slot_software_timer #(
  parameter int SLOTS = mst_pkg::SLOTS_DEF
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          start,
  output logic          busy,
  input  mst_pkg::in_t  in_data,
  output logic          out_valid,
  output mst_pkg::out_t out_data
);

  localparam int AW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int TW = mst_pkg::TW;

  mst_pkg::ctrl_t ctl;
  logic [AW-1:0]  rd_addr;
  logic [AW-1:0]  proc_idx;
  logic           accept;
  logic           go_service;
  logic           in_bank;
  logic [AW-1:0]  slot_addr;

  logic [TW-1:0]    tick_r, tick_nxt;
  logic [SLOTS-1:0] active_r, active_nxt;
  logic [SLOTS-1:0] loaded_r, loaded_nxt;
  logic             pend_valid_r, pend_valid_nxt;
  logic [AW-1:0]    pend_slot_r, pend_slot_nxt;
  logic             out_valid_r, out_valid_nxt;
  mst_pkg::out_t    out_r, out_nxt;

  logic            we;
  logic [AW-1:0]   waddr;
  logic [2*TW-1:0] wdata;
  logic [2*TW-1:0] rdata;
  logic [TW-1:0]   dl;
  logic [TW-1:0]   iv;
  logic [TW-1:0]   add_op;
  logic [TW-1:0]   add_sum;
  logic            hit;

  assign busy       = ctl.busy;
  assign accept     = start && !ctl.busy;
  assign go_service = accept && (in_data.opcode == mst_pkg::OP_SERVICE);
  assign in_bank    = ({28'd0, in_data.slot} < 32'(SLOTS));
  assign slot_addr  = AW'(in_data.slot);

  // scan sequencer
  mst_ctrl #(.SLOTS(SLOTS)) u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .go_service (go_service),
    .ctl        (ctl),
    .rd_addr    (rd_addr),
    .proc_idx   (proc_idx)
  );

  // slot memory: deadline in the upper word, repeat interval in the lower
  mst_ram #(.WIDTH(2 * TW), .DEPTH(SLOTS)) u_ram (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .re    (ctl.rd_en),
    .raddr (rd_addr),
    .rdata (rdata)
  );

  // entry under service, unloaded entries read as zero
  assign dl  = loaded_r[proc_idx] ? rdata[2*TW-1:TW] : '0;
  assign iv  = loaded_r[proc_idx] ? rdata[TW-1:0] : '0;
  assign hit = ctl.proc_valid && active_r[proc_idx] && (tick_r >= dl);

  // shared adder: load delay or rearm interval
  assign add_op  = ctl.proc_valid ? iv : in_data.delay;
  assign add_sum = tick_r + add_op;

  // opcode handling and scan write-back
  always_comb begin
    tick_nxt       = tick_r;
    active_nxt     = active_r;
    loaded_nxt     = loaded_r;
    pend_valid_nxt = pend_valid_r;
    pend_slot_nxt  = pend_slot_r;
    out_valid_nxt  = 1'b0;
    out_nxt        = out_r;
    we             = 1'b0;
    waddr          = slot_addr;
    wdata          = {add_sum, in_data.period};

    // accepted commands; service answers with no beat here
    if (accept) begin
      out_nxt.kind       = mst_pkg::KIND_ACK;
      out_nxt.fired_slot = in_data.slot;
      out_nxt.last       = 1'b1;
      out_valid_nxt      = 1'b1;
      unique case (in_data.opcode)
        mst_pkg::OP_TICK: begin
          tick_nxt = tick_r + 1'b1;
        end
        mst_pkg::OP_LOAD: begin
          if (in_bank) begin
            we                    = 1'b1;
            loaded_nxt[slot_addr] = 1'b1;
          end
        end
        mst_pkg::OP_START: begin
          if (in_bank && active_r[slot_addr]) begin
            out_nxt.kind = mst_pkg::KIND_BUSY;
          end else if (in_bank) begin
            active_nxt[slot_addr] = 1'b1;
          end
        end
        mst_pkg::OP_STOP: begin
          if (in_bank) begin
            active_nxt[slot_addr] = 1'b0;
          end
        end
        mst_pkg::OP_SERVICE: begin
          out_valid_nxt  = 1'b0;
          pend_valid_nxt = 1'b0;
        end
        default: begin
          out_nxt.kind = mst_pkg::KIND_ACK;
        end
      endcase
    end

    // expired slot: release the held beat, hold this one, rearm or stop
    if (hit) begin
      if (pend_valid_r) begin
        out_valid_nxt      = 1'b1;
        out_nxt.kind       = mst_pkg::KIND_FIRED;
        out_nxt.fired_slot = 4'(pend_slot_r);
        out_nxt.last       = 1'b0;
      end
      pend_valid_nxt = 1'b1;
      pend_slot_nxt  = proc_idx;
      if (iv == '0) begin
        active_nxt[proc_idx] = 1'b0;
      end else begin
        we                   = 1'b1;
        waddr                = proc_idx;
        wdata                = {add_sum, iv};
        loaded_nxt[proc_idx] = 1'b1;
      end
    end

    // closing beat of a service
    if (ctl.flush) begin
      out_valid_nxt = 1'b1;
      out_nxt.last  = 1'b1;
      if (pend_valid_r) begin
        out_nxt.kind       = mst_pkg::KIND_FIRED;
        out_nxt.fired_slot = 4'(pend_slot_r);
      end else begin
        out_nxt.kind       = mst_pkg::KIND_NONE;
        out_nxt.fired_slot = '0;
      end
    end
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tick_r       <= '0;
      active_r     <= '0;
      loaded_r     <= '0;
      pend_valid_r <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      tick_r       <= tick_nxt;
      active_r     <= active_nxt;
      loaded_r     <= loaded_nxt;
      pend_valid_r <= pend_valid_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    pend_slot_r <= pend_slot_nxt;
    out_r       <= out_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

endmodule

// ----- src/mst_ram.sv -----
// mst_ram: generic single-clock ram, one write port, one registered read port
// no dependencies
module mst_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// ----- src/mst_ctrl.sv -----
// mst_ctrl: service scan sequencer, walks the slot memory one entry a cycle
// depends on mst_pkg
module mst_ctrl #(
  parameter int SLOTS = mst_pkg::SLOTS_DEF,
  localparam int AW = (SLOTS > 1) ? $clog2(SLOTS) : 1
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           go_service,
  output mst_pkg::ctrl_t ctl,
  output logic [AW-1:0]  rd_addr,
  output logic [AW-1:0]  proc_idx
);

  localparam int CW = $clog2(SLOTS + 1);

  mst_pkg::state_t state_r, state_nxt;
  logic [CW-1:0]   cnt_r, cnt_nxt;
  logic [CW-1:0]   cnt_m1;

  // next state and scan counter
  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    unique case (state_r)
      mst_pkg::ST_IDLE: begin
        cnt_nxt = '0;
        if (go_service) begin
          state_nxt = mst_pkg::ST_SCAN;
        end
      end
      mst_pkg::ST_SCAN: begin
        cnt_nxt = cnt_r + 1'b1;
        if (cnt_r == CW'(SLOTS)) begin
          state_nxt = mst_pkg::ST_FLUSH;
        end
      end
      mst_pkg::ST_FLUSH: begin
        state_nxt = mst_pkg::ST_IDLE;
      end
      default: begin
        state_nxt = mst_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= mst_pkg::ST_IDLE;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

  // read slot cnt, process slot cnt - 1, read in the previous cycle
  assign cnt_m1   = cnt_r - 1'b1;
  assign rd_addr  = cnt_r[AW-1:0];
  assign proc_idx = cnt_m1[AW-1:0];

  // status outputs
  always_comb begin
    ctl = '0;
    unique case (state_r)
      mst_pkg::ST_IDLE: begin
        ctl.busy = 1'b0;
      end
      mst_pkg::ST_SCAN: begin
        ctl.busy       = 1'b1;
        ctl.rd_en      = (cnt_r != CW'(SLOTS));
        ctl.proc_valid = (cnt_r != '0);
      end
      mst_pkg::ST_FLUSH: begin
        ctl.busy  = 1'b1;
        ctl.flush = 1'b1;
      end
      default: begin
        ctl.busy = 1'b1;
      end
    endcase
  end

endmodule
